// ----- rtl/hlxd_pkg.sv -----
// Shared types, constants and register codes of the header/length/XOR deframer.
package hlxd_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 8;

   typedef logic [BYTE_W-1:0] byte_type;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SYNC_FIRST  = 1'b0,
      CSR_SYNC_SECOND = 1'b1
   } csr_index_type;

   localparam byte_type SYNC_FIRST_RESET  = 8'd170;
   localparam byte_type SYNC_SECOND_RESET = 8'd85;

   // Parser phases; the codes left over behave as the first-header hunt
   typedef enum logic [2:0] {
      PH_HUNT_FIRST  = 3'd0,
      PH_HUNT_SECOND = 3'd1,
      PH_LENGTH      = 3'd2,
      PH_PAYLOAD     = 3'd3,
      PH_CHECK       = 3'd4
   } phase_type;

   // Header values seen by the parser
   typedef struct packed {
      byte_type sync_first;
      byte_type sync_second;
   } sync_cfg_type;

   // One result beat
   typedef struct packed {
      byte_type payload_byte;
      logic     frame_end;
      logic     frame_good;
      byte_type frame_length;
   } result_type;

endpackage

// ----- rtl/hlxd_if.sv -----
// Valid/ready stream interfaces for received bytes and deframer results.
interface hlxd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hlxd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       frame_end;
   logic       frame_good;
   logic [7:0] frame_length;

   modport source (output valid, output payload_byte, output frame_end,
                   output frame_good, output frame_length, input ready);
   modport sink   (input valid, input payload_byte, input frame_end,
                   input frame_good, input frame_length, output ready);
endinterface

// ----- rtl/hlxd_csr.sv -----
// Header value registers written through the plain configuration port.
module hlxd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [hlxd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hlxd_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   output hlxd_pkg::sync_cfg_type           sync_cfg
);
   import hlxd_pkg::*;

   byte_type sync_first_ff, sync_first_in;
   byte_type sync_second_ff, sync_second_in;

   // Decode the write
   always_comb begin
      sync_first_in  = sync_first_ff;
      sync_second_in = sync_second_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SYNC_FIRST:  sync_first_in  = csr_wr_data[BYTE_W-1:0];
            CSR_SYNC_SECOND: sync_second_in = csr_wr_data[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_RESET;
         sync_second_ff <= SYNC_SECOND_RESET;
      end else begin
         sync_first_ff  <= sync_first_in;
         sync_second_ff <= sync_second_in;
      end
   end

   assign sync_cfg.sync_first  = sync_first_ff;
   assign sync_cfg.sync_second = sync_second_ff;

endmodule

// ----- rtl/hlxd_parse.sv -----
// Input byte register and frame parser: header hunt, length, payload, checksum.
module hlxd_parse (
   input  logic                     clock,
   input  logic                     reset,
   hlxd_req_if.sink                 req_chan,
   input  hlxd_pkg::sync_cfg_type   sync_cfg,
   input  logic                     res_ready,
   output logic                     res_valid,
   output hlxd_pkg::result_type     res_data
);
   import hlxd_pkg::*;

   logic      in_valid_ff, in_valid_in;
   byte_type  in_byte_ff;
   phase_type phase_ff, phase_in;
   byte_type  bytes_left_ff, bytes_left_in;
   byte_type  running_xor_ff, running_xor_in;
   byte_type  length_seen_ff, length_seen_in;
   logic      consume;
   logic      emit;
   byte_type  b;

   assign b       = in_byte_ff;
   assign consume = in_valid_ff && res_ready;
   assign req_chan.ready = !in_valid_ff || consume;

   // Hold the input beat until the parser takes it
   assign in_valid_in = req_chan.valid || (in_valid_ff && !consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   // Next phase and frame counters
   always_comb begin
      phase_in       = phase_ff;
      bytes_left_in  = bytes_left_ff;
      running_xor_in = running_xor_ff;
      length_seen_in = length_seen_ff;
      if (consume) begin
         unique case (phase_ff)
            PH_HUNT_SECOND: begin
               if (b == sync_cfg.sync_second) begin
                  phase_in = PH_LENGTH;
               end else if (b == sync_cfg.sync_first) begin
                  phase_in = PH_HUNT_SECOND;
               end else begin
                  phase_in = PH_HUNT_FIRST;
               end
            end
            PH_LENGTH: begin
               length_seen_in = b;
               running_xor_in = b;
               bytes_left_in  = b;
               phase_in       = (b == '0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               running_xor_in = running_xor_ff ^ b;
               bytes_left_in  = bytes_left_ff - byte_type'(1);
               if (bytes_left_ff == byte_type'(1)) begin
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               phase_in = PH_HUNT_FIRST;
            end
            default: begin
               phase_in = (b == sync_cfg.sync_first) ? PH_HUNT_SECOND : PH_HUNT_FIRST;
            end
         endcase
      end
   end

   // Result beat for payload and checksum bytes
   always_comb begin
      emit                  = 1'b0;
      res_data.payload_byte = '0;
      res_data.frame_end    = 1'b0;
      res_data.frame_good   = 1'b0;
      res_data.frame_length = length_seen_ff;
      unique case (phase_ff)
         PH_PAYLOAD: begin
            emit                  = 1'b1;
            res_data.payload_byte = b;
         end
         PH_CHECK: begin
            emit                = 1'b1;
            res_data.frame_end  = 1'b1;
            res_data.frame_good = (b == running_xor_ff);
         end
         default: ;
      endcase
   end

   assign res_valid = consume && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT_FIRST;
         bytes_left_ff  <= '0;
         running_xor_ff <= '0;
         length_seen_ff <= '0;
      end else begin
         phase_ff       <= phase_in;
         bytes_left_ff  <= bytes_left_in;
         running_xor_ff <= running_xor_in;
         length_seen_ff <= length_seen_in;
      end
   end

   // A payload phase always has at least one byte still to come
   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> bytes_left_ff != '0)
      else $error("payload phase with zero bytes left");

   // A length byte seeds the checksum and the counter
   a_length_seed: assert property (@(posedge clock) disable iff (reset)
      (consume && phase_ff == PH_LENGTH) |=>
         (running_xor_ff == length_seen_ff) && (bytes_left_ff == length_seen_ff))
      else $error("length byte did not seed checksum and count");

   // A checksum byte returns the parser to the hunt
   a_check_exit: assert property (@(posedge clock) disable iff (reset)
      (consume && phase_ff == PH_CHECK) |=> phase_ff == PH_HUNT_FIRST)
      else $error("parser did not resume hunt after checksum");

   // Results come only from consumed payload or checksum bytes
   a_emit_source: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> consume && (phase_ff == PH_PAYLOAD || phase_ff == PH_CHECK))
      else $error("result beat without payload or checksum byte");

endmodule

// ----- rtl/hlxd_out.sv -----
// Result register that drives the response channel.
module hlxd_out (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  res_valid,
   input  hlxd_pkg::result_type  res_data,
   output logic                  res_ready,
   hlxd_rsp_if.source            rsp_chan
);
   import hlxd_pkg::*;

   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff;

   // Take a new beat when empty or when the current one leaves
   assign res_ready    = !out_valid_ff || rsp_chan.ready;
   assign out_valid_in = res_valid || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         out_data_ff <= res_data;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.payload_byte = out_data_ff.payload_byte;
   assign rsp_chan.frame_end    = out_data_ff.frame_end;
   assign rsp_chan.frame_good   = out_data_ff.frame_good;
   assign rsp_chan.frame_length = out_data_ff.frame_length;

endmodule

// ----- rtl/header_length_xor_deframer.sv -----
// Top level of the header/length/XOR-checksum frame deframer.
// Accepts one received byte per cycle while the response port is not
// stalled, and recovers frames of the form header (two configurable sync
// bytes), length byte L, L payload bytes and a checksum byte equal to the
// XOR of the length byte and the payload. Bytes before a header are dropped.
// Each payload byte comes out as its own beat; the checksum byte gives a
// frame-end beat with frame_good and frame_length, so downstream can discard
// the payload of a bad frame. After any frame the hunt starts again right
// after its checksum byte. A byte passes through the input register and then
// the result register on its way to the response port. Write the sync
// registers only while the block is idle.
module header_length_xor_deframer (
   input  logic                             clock,
   input  logic                             reset,
   hlxd_req_if.sink                         req_chan,
   hlxd_rsp_if.source                       rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [hlxd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hlxd_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import hlxd_pkg::*;

   sync_cfg_type sync_cfg;
   logic         res_valid;
   logic         res_ready;
   result_type   res_data;

   hlxd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .sync_cfg    (sync_cfg)
   );

   hlxd_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .sync_cfg  (sync_cfg),
      .res_ready (res_ready),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   hlxd_out u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_ready (res_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the header/length/XOR-checksum frame deframer.
module tb_top;
   import hlxd_pkg::*;

   localparam int unsigned BLOCK_LATENCY = 2;
   localparam int unsigned MAX_REPORTS   = 40;
   localparam int unsigned RUN_LIMIT     = 4_000_000;

   typedef enum int unsigned {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_type;

   logic clock = 1'b0;
   logic reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   hlxd_req_if req_bus ();
   hlxd_rsp_if rsp_bus ();

   header_length_xor_deframer uut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_bus),
      .rsp_chan   (rsp_bus),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   // Predicted deframer state and header setting
   byte_type  hdr_first  = SYNC_FIRST_RESET;
   byte_type  hdr_second = SYNC_SECOND_RESET;
   phase_type pred_phase = PH_HUNT_FIRST;
   byte_type  bytes_left = '0;
   byte_type  running_xor = '0;
   byte_type  len_seen = '0;

   result_type pending_results[$];

   // Run bookkeeping
   int unsigned errors = 0;
   int unsigned beats_sent = 0;
   int unsigned beats_checked = 0;
   int unsigned frames_good = 0;
   int unsigned frames_bad = 0;
   int unsigned header_settings = 1;
   int unsigned burst_left = 0;
   bit          gaps_on = 1'b1;

   result_type seen, want;

   // Clock generation
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the predicted parser by one received byte
   function automatic void deframe_byte(input byte_type b);
      result_type r;
      case (pred_phase)
         PH_HUNT_SECOND: begin
            if (b == hdr_second)
               pred_phase = PH_LENGTH;
            else if (b == hdr_first)
               pred_phase = PH_HUNT_SECOND;
            else
               pred_phase = PH_HUNT_FIRST;
         end
         PH_LENGTH: begin
            len_seen    = b;
            running_xor = b;
            bytes_left  = b;
            pred_phase  = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            running_xor = running_xor ^ b;
            bytes_left  = bytes_left - 8'd1;
            if (bytes_left == 8'd0)
               pred_phase = PH_CHECK;
            r.payload_byte = b;
            r.frame_end    = 1'b0;
            r.frame_good   = 1'b0;
            r.frame_length = len_seen;
            pending_results.push_back(r);
         end
         PH_CHECK: begin
            r.payload_byte = '0;
            r.frame_end    = 1'b1;
            r.frame_good   = (b == running_xor);
            r.frame_length = len_seen;
            pending_results.push_back(r);
            pred_phase = PH_HUNT_FIRST;
         end
         default: begin
            pred_phase = (b == hdr_first) ? PH_HUNT_SECOND : PH_HUNT_FIRST;
         end
      endcase
   endfunction

   // Send one byte beat, with bursts and random gaps ahead of it
   task automatic send_byte(input byte_type b);
      int unsigned gap;
      if (gaps_on && burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
         repeat (gap) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
         end
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0)
         burst_left--;
      @(negedge clock);
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do
         @(posedge clock);
      while (!req_bus.ready);
      deframe_byte(b);
      beats_sent++;
   endtask

   // Send a full frame under the current header; optionally break the checksum
   task automatic send_frame(input byte_type len, input bit corrupt, input fill_type fill);
      byte_type chk;
      byte_type b;
      chk = len;
      send_byte(hdr_first);
      send_byte(hdr_second);
      send_byte(len);
      for (int i = 0; i < len; i++) begin
         case (fill)
            FILL_ZERO: b = 8'h00;
            FILL_ONES: b = 8'hFF;
            default: begin
               case ($urandom_range(0, 9))
                  0:       b = hdr_first;
                  1:       b = hdr_second;
                  default: b = byte_type'($urandom_range(0, 255));
               endcase
            end
         endcase
         chk = chk ^ b;
         send_byte(b);
      end
      if (corrupt)
         chk = chk ^ byte_type'($urandom_range(1, 255));
      send_byte(chk);
   endtask

   // Drop valid and hold until every expected beat is out and the pipe is empty
   task automatic settle_block();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (BLOCK_LATENCY + 2) @(posedge clock);
   endtask

   // Write one sync register; the block must be idle
   task automatic write_csr(input csr_index_type idx, input byte_type val);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_SYNC_FIRST:  hdr_first  = val;
         CSR_SYNC_SECOND: hdr_second = val;
         default: ;
      endcase
   endtask

   task automatic set_header(input byte_type first, input byte_type second);
      settle_block();
      write_csr(CSR_SYNC_FIRST, first);
      write_csr(CSR_SYNC_SECOND, second);
      header_settings++;
   endtask

   // Reset header: dropped bytes, zero length, repeated first byte, bad checksum
   task automatic test_reset_header();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(8'd0, 1'b0, FILL_RANDOM);
      send_byte(hdr_first);
      send_frame(8'd1, 1'b0, FILL_ONES);
      send_byte(8'h11);
      send_frame(8'd2, 1'b1, FILL_RANDOM);
   endtask

   // Extreme and equal header values, and a register change inside a frame
   task automatic test_header_registers();
      set_header(8'h00, 8'hFF);
      send_frame(8'd3, 1'b0, FILL_ZERO);
      set_header(8'hFF, 8'h00);
      send_frame(8'd2, 1'b1, FILL_ONES);
      set_header(8'h7E, 8'h7E);
      send_frame(8'd2, 1'b0, FILL_RANDOM);
      set_header(SYNC_FIRST_RESET, SYNC_SECOND_RESET);
      send_byte(hdr_first);
      send_byte(hdr_second);
      send_byte(8'h03);
      settle_block();
      write_csr(CSR_SYNC_FIRST, 8'h3C);
      send_byte(8'h12);
      send_byte(8'h34);
      send_byte(8'h3C);
      send_byte(8'h03 ^ 8'h12 ^ 8'h34 ^ 8'h3C);
      send_frame(8'd0, 1'b0, FILL_RANDOM);
   endtask

   // Longest frame
   task automatic test_max_length();
      send_frame(8'd255, 1'b0, FILL_RANDOM);
   endtask

   // Mostly well-formed frames with random content, plus noise and broken frames
   task automatic test_random_traffic(input byte_type first, input byte_type second,
                                      input bit with_gaps, input int unsigned n_items);
      int unsigned stop_at;
      int unsigned pick;
      int unsigned len;
      int unsigned cut;
      set_header(first, second);
      gaps_on = with_gaps;
      stop_at = beats_sent + n_items;
      while (beats_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            case ($urandom_range(0, 19))
               0:          len = $urandom_range(33, 80);
               1, 2, 3, 4: len = $urandom_range(9, 32);
               default:    len = $urandom_range(0, 8);
            endcase
            send_frame(byte_type'(len), ($urandom_range(0, 3) == 0), FILL_RANDOM);
         end else if (pick < 75) begin
            repeat ($urandom_range(1, 4))
               send_byte(($urandom_range(0, 2) == 0) ? hdr_first
                                                     : byte_type'($urandom_range(0, 255)));
         end else if (pick < 85) begin
            send_byte(hdr_first);
            send_byte(byte_type'($urandom_range(0, 255)));
         end else if (pick < 95) begin
            // header and length, then cut the frame short
            len = $urandom_range(1, 6);
            cut = $urandom_range(0, len - 1);
            send_byte(hdr_first);
            send_byte(hdr_second);
            send_byte(byte_type'(len));
            repeat (cut) send_byte(byte_type'($urandom_range(0, 255)));
         end else begin
            settle_block();
         end
      end
      gaps_on = 1'b1;
   endtask

   // Receiver ready: switches at random between stall modes
   initial begin
      int unsigned mode_cycles;
      int unsigned stall_mode;
      int unsigned pattern_cnt;
      logic        rdy;
      mode_cycles = 0;
      stall_mode  = 0;
      pattern_cnt = 0;
      rsp_bus.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (mode_cycles == 0) begin
            stall_mode  = $urandom_range(0, 3);
            mode_cycles = $urandom_range(50, 300);
         end
         mode_cycles--;
         pattern_cnt++;
         case (stall_mode)
            0:       rdy = 1'b1;
            1:       rdy = ($urandom_range(0, 3) != 0);
            2:       rdy = ((pattern_cnt % 7) < 4);
            default: rdy = ((pattern_cnt % 20) < 8);
         endcase
         rsp_bus.ready <= rdy;
      end
   end

   task automatic check_field(input string field, input int unsigned exp_v,
                              input int unsigned act_v);
      if (exp_v != act_v) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, exp_v, act_v);
      end
   endtask

   // Compare each result beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.payload_byte = rsp_bus.payload_byte;
         seen.frame_end    = rsp_bus.frame_end;
         seen.frame_good   = rsp_bus.frame_good;
         seen.frame_length = rsp_bus.frame_length;
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: unexpected result beat: expected none, actual %0h",
                        $time, seen);
         end else begin
            want = pending_results.pop_front();
            check_field("payload_byte", 32'(want.payload_byte), 32'(seen.payload_byte));
            check_field("frame_end", 32'(want.frame_end), 32'(seen.frame_end));
            check_field("frame_good", 32'(want.frame_good), 32'(seen.frame_good));
            check_field("frame_length", 32'(want.frame_length), 32'(seen.frame_length));
            beats_checked++;
            if (want.frame_end) begin
               if (want.frame_good)
                  frames_good++;
               else
                  frames_bad++;
            end
         end
      end
   end

   // Run limit
   initial begin
      #(RUN_LIMIT);
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("end of test: mismatches");
      $finish;
   end

   // Test sequence
   initial begin
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_index     = '0;
      csr_wr_data   = '0;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_header();
      test_header_registers();
      test_max_length();
      test_random_traffic(byte_type'($urandom_range(0, 255)),
                          byte_type'($urandom_range(0, 255)), 1'b1, 40);
      test_random_traffic(8'hFF, 8'hFF, 1'b0, 40);
      test_random_traffic(SYNC_FIRST_RESET, SYNC_SECOND_RESET, 1'b1, 40);
      settle_block();
      repeat (10) @(posedge clock);
      if (pending_results.size() != 0) begin
         errors++;
         $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      end

      $display("Run covered %0d input bytes and %0d result beats under %0d header settings.",
               beats_sent, beats_checked, header_settings);
      $display("Frames closed: %0d with good checksum, %0d with bad; %0d mismatches.",
               frames_good, frames_bad, errors);
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
